[design/baud_divisor_search_core_defines.svh]
// Assertion macros shared by the baud divisor search design.
`ifndef BAUD_DIVISOR_SEARCH_CORE_DEFINES_SVH
`define BAUD_DIVISOR_SEARCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define BDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define BDS_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDS_ASSERT(label, prop, msg)
`define BDS_ASSERT_NEVER(label, expr, msg)
`endif

`endif

[design/bds_pkg.sv]
// Shared constants, types and helper functions of the baud divisor search.
package bds_pkg;

    localparam int NUM_CELLS      = 15;
    localparam int NEG_CELLS      = 7;
    localparam int CELL_W         = 4;
    localparam int CLK_W          = 26;
    localparam int BAUD_W         = 22;
    localparam int DIV_W          = 33;
    localparam int CNT_W          = 6;
    localparam int EST_W          = 16;
    localparam int PERIOD_W       = 12;
    localparam int ERR_W          = 24;
    localparam int SCALE_W        = 4;
    localparam int SHIFT_W        = 3;
    localparam int PRESCALE_SHIFT = 3;

    localparam logic [CLK_W-1:0]    CLOCK_RESET = 26'd32000000;
    localparam logic [EST_W-1:0]    PERIOD_MAX  = 16'd4095;
    localparam logic [ERR_W-1:0]    ERROR_LIMIT = 24'd10000000;

    // Candidate carried from cell to cell along with its best match so far.
    typedef struct packed {
        logic [BAUD_W-1:0]          baud;
        logic [ERR_W-1:0]           best_err;
        logic signed [SCALE_W-1:0]  scale;
        logic [PERIOD_W-1:0]        period;
    } bds_item_t;

    // Request to the iterative divider.
    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DIV_W-1:0]   divisor;
    } bds_div_req_t;

    // Answer from the iterative divider.
    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } bds_div_rsp_t;

    // True for the cells that try negative scale exponents.
    function automatic logic cell_is_neg(input logic [CELL_W-1:0] slot);
        return slot < CELL_W'(NEG_CELLS);
    endfunction

    // Magnitude of the scale exponent a cell tries.
    function automatic logic [SHIFT_W-1:0] cell_shift(input logic [CELL_W-1:0] slot);
        logic [CELL_W-1:0] s;
        s = cell_is_neg(slot) ? slot + CELL_W'(1) : slot - CELL_W'(NEG_CELLS);
        return s[SHIFT_W-1:0];
    endfunction

endpackage

[design/bds_req_if.sv]
// Input channel carrying the requested baud rate.
interface bds_req_if;
    import bds_pkg::*;

    logic                valid;
    logic                ready;
    logic [BAUD_W-1:0]   target_baud;

    modport source (output valid, output target_baud, input ready);
    modport sink   (input valid, input target_baud, output ready);
endinterface

[design/bds_rsp_if.sv]
// Output channel carrying the chosen scale exponent and period value.
interface bds_rsp_if;
    import bds_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SCALE_W-1:0]  scale_exponent;
    logic [PERIOD_W-1:0]        period_value;

    modport source (output valid, output scale_exponent, output period_value, input ready);
    modport sink   (input valid, input scale_exponent, input period_value, output ready);
endinterface

[design/bds_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module bds_div
    import bds_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bds_div_req_t  req,
    output bds_div_rsp_t  rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    dq_reg, dq_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [DIV_W:0]      trial;
    logic                fits;

    // One step: bring down the next dividend bit and try to subtract.
    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
            dq_next  = {dq_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule

[design/bds_cell.sv]
// One cell of the search chain: evaluates a single scale exponent candidate.
module bds_cell
    import bds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CELL_W-1:0]   slot,
    input  logic [CLK_W-1:0]    clock_frequency,
    input  logic                in_valid,
    output logic                in_ready,
    input  bds_item_t           in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output bds_item_t           out_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START1,
        S_DIV1,
        S_START2,
        S_DIV2,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    bds_item_t           item_reg, item_next;
    bds_item_t           out_item_reg, out_item_next;
    logic                out_valid_reg, out_valid_next;
    logic [EST_W-1:0]    est_reg, est_next;

    logic                is_neg;
    logic [SHIFT_W-1:0]  n;
    logic [DIV_W-1:0]    clk_ext, baud_ext, f_neg, pw, d_pos;
    logic [DIV_W-1:0]    div1_dividend, div1_divisor;
    logic [DIV_W-1:0]    d2, div2_dividend;
    logic [EST_W-1:0]    est_calc;
    logic [DIV_W-1:0]    diff;
    logic                better;
    logic [SCALE_W-1:0]  scale_bits;
    bds_div_req_t        div_req;
    bds_div_rsp_t        div_rsp;

    bds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Candidate constants of this cell.
    assign is_neg   = cell_is_neg(slot);
    assign n        = cell_shift(slot);
    assign clk_ext  = DIV_W'(clock_frequency);
    assign baud_ext = DIV_W'(item_reg.baud);
    assign f_neg    = (n >= SHIFT_W'(PRESCALE_SHIFT)) ?
                      clk_ext << (n - SHIFT_W'(PRESCALE_SHIFT)) :
                      clk_ext >> (SHIFT_W'(PRESCALE_SHIFT) - n);
    assign pw       = DIV_W'(1) << n;
    assign d_pos    = baud_ext << ({1'b0, n} + 4'(PRESCALE_SHIFT));

    // First division estimates the period value.
    assign div1_divisor  = is_neg ? baud_ext : d_pos;
    assign div1_dividend = is_neg ? f_neg + (baud_ext >> 1) : clk_ext + (d_pos >> 1);
    assign est_calc      = is_neg ? div_rsp.quotient[EST_W-1:0] - pw[EST_W-1:0] :
                                    div_rsp.quotient[EST_W-1:0] - EST_W'(1);

    // Second division finds the rate the estimate actually achieves.
    assign d2            = is_neg ? DIV_W'(est_reg) + pw : (DIV_W'(est_reg) + DIV_W'(1)) << n;
    assign div2_dividend = is_neg ? f_neg + (d2 >> 1) :
                                    (clk_ext >> PRESCALE_SHIFT) + (d2 >> 1);

    assign div_req.start    = (state_reg == S_START1) || (state_reg == S_START2);
    assign div_req.dividend = (state_reg == S_START1) ? div1_dividend : div2_dividend;
    assign div_req.divisor  = (state_reg == S_START1) ? div1_divisor : d2;

    // Error against the target and the strict improvement test.
    assign diff       = (div_rsp.quotient >= baud_ext) ? div_rsp.quotient - baud_ext :
                                                         baud_ext - div_rsp.quotient;
    assign better     = diff < DIV_W'(item_reg.best_err);
    assign scale_bits = is_neg ? SCALE_W'(0) - {1'b0, n} : {1'b0, n};

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        est_next       = est_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = (in_item.baud == '0) ? S_FIN : S_START1;
                end
            end
            S_START1:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    est_next   = est_calc;
                    state_next = (est_calc <= PERIOD_MAX) ? S_START2 : S_FIN;
                end
            end
            S_START2:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    if (better)
                    begin
                        item_next.best_err = diff[ERR_W-1:0];
                        item_next.scale    = $signed(scale_bits);
                        item_next.period   = est_reg[PERIOD_W-1:0];
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_item_next  = item_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        est_reg      <= est_next;
        out_item_reg <= out_item_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[design/baud_divisor_search_core.sv]
// Top level of the baud divisor search: configuration register and cell chain.
//
// A transaction on req carries a target baud rate; one transaction on rsp
// returns the scale exponent (-7..7) and 12-bit period value whose achieved
// rate is closest to it, or 0, 0 when no candidate comes within the limit.
// The clock frequency register is written with cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. Reset loads 32,000,000 and empties the chain.
// Fifteen cells in a row each try one scale exponent, negative ones first,
// and pass the request and the best match so far to the next cell.
// Each cell works on one request at a time through its two 33-step
// divisions and takes a new one once it has handed the last to its output
// register, so up to thirty requests can be in flight. A cell whose period
// estimate is out of range skips the second division; a zero target skips
// both. When the receiver stalls, results wait in the cell output registers
// and the chain fills up until req.ready drops; nothing is lost.
`include "baud_divisor_search_core_defines.svh"

module baud_divisor_search_core
    import bds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    bds_req_if.sink            req,
    bds_rsp_if.source          rsp,
    input  logic               cfg_wr_en,
    input  logic [CLK_W-1:0]   cfg_wr_data
);

    logic [CLK_W-1:0]  clock_frequency_reg;
    logic              link_valid [NUM_CELLS+1];
    logic              link_ready [NUM_CELLS+1];
    bds_item_t         link_item  [NUM_CELLS+1];

    // Clock frequency register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_frequency_reg <= CLOCK_RESET;
        end
        else if (cfg_wr_en)
        begin
            clock_frequency_reg <= cfg_wr_data;
        end
    end

    // Requests enter the chain with the initial best match.
    assign link_valid[0]          = req.valid;
    assign req.ready              = link_ready[0];
    assign link_item[0].baud      = req.target_baud;
    assign link_item[0].best_err  = ERROR_LIMIT;
    assign link_item[0].scale     = '0;
    assign link_item[0].period    = '0;

    // Chain of candidate cells.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        bds_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .slot            (CELL_W'(i)),
            .clock_frequency (clock_frequency_reg),
            .in_valid        (link_valid[i]),
            .in_ready        (link_ready[i]),
            .in_item         (link_item[i]),
            .out_valid       (link_valid[i+1]),
            .out_ready       (link_ready[i+1]),
            .out_item        (link_item[i+1])
        );
    end

    // The last cell's output register drives the result channel.
    assign rsp.valid                = link_valid[NUM_CELLS];
    assign link_ready[NUM_CELLS]    = rsp.ready;
    assign rsp.scale_exponent       = link_item[NUM_CELLS].scale;
    assign rsp.period_value         = link_item[NUM_CELLS].period;

    // The first cell is not ready again straight after taking a transaction.
    `BDS_ASSERT(a_first_cell_busy, req.valid && req.ready |=> !req.ready, "first cell accepted twice in a row")
    // A scale exponent of -8 is never produced.
    `BDS_ASSERT_NEVER(a_scale_range, rsp.valid && rsp.scale_exponent == 4'sb1000, "scale exponent out of range")
    // The best error leaving the chain never exceeds the starting limit.
    `BDS_ASSERT_NEVER(a_best_err_limit, link_valid[NUM_CELLS] && link_item[NUM_CELLS].best_err > ERROR_LIMIT, "best error above limit")

endmodule
